FILE: hw/rtl/itqe_pkg.sv
// Package of the table quantile engine: widths, codes, control word format and microcode ROM.
package itqe_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int ENTRY_BITS_DEF = 32;
    localparam int SIZE_CFG_W     = 11;
    localparam int SIZE_RESET     = 128;
    localparam int OP_W           = 3;
    localparam int IDX_W          = 32;
    localparam int VALUE_W        = 32;
    localparam int FRAC_W         = 15;
    localparam int RESULT_W       = 48;
    localparam int PROD_W         = 64;
    localparam int LEFT_W         = 50;
    localparam int MUL_CNT_W      = 4;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    // Word index of the size register on the configuration port.
    localparam logic REG_SIZE_CFG = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 3'd0,
        OP_READ     = 3'd1,
        OP_FILL     = 3'd2,
        OP_INVERSE  = 3'd3,
        OP_QUANTILE = 3'd4,
        OP_SUM      = 3'd5
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WR, S_RD0, S_RD1, S_FILL,
        S_INV_P, S_INV_W, S_INV_HIT, S_INV_NONE,
        S_SUM_P, S_SUM_L, S_SUM_E,
        S_Q_P, S_Q_SUM, S_Q_Z, S_Q_ZERO, S_Q_MUL, S_Q_LD, S_Q_P2, S_Q_W,
        S_Q_HIT, S_Q_MISS
    } step_t;

    typedef enum logic [3:0] {
        C_NONE, C_IN_VALID, C_CLR_LAST, C_ADDR_LAST, C_DIX_LAST,
        C_OUT_FREE, C_ACC_ZERO, C_MUL_LAST, C_GT, C_HIT
    } cond_t;

    typedef enum logic [1:0] {A_HOLD, A_LOAD, A_ZERO, A_INC} addr_op_t;
    typedef enum logic [1:0] {W_NONE, W_ZERO, W_VALUE} wr_op_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {M_HOLD, M_INIT, M_STEP} mul_op_t;
    typedef enum logic [1:0] {L_HOLD, L_LOAD, L_SUB} left_op_t;
    typedef enum logic [2:0] {R_RDATA, R_ACC, R_ZERO, R_CAP, R_CAPM1, R_SIZEM1} res_sel_t;

    typedef struct packed {
        logic     accept;
        logic     dispatch;
        addr_op_t addr_op;
        wr_op_t   wr_op;
        acc_op_t  acc_op;
        mul_op_t  mul_op;
        left_op_t left_op;
        logic     cap;
        res_sel_t res_sel;
        logic     emit;
        cond_t    c1;
        step_t    t1;
        cond_t    c2;
        step_t    t2;
        step_t    t_else;
    } ctrl_t;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            clr_last;
        logic            addr_last;
        logic            dix_last;
        logic            out_free;
        logic            acc_zero;
        logic            mul_last;
        logic            gt;
        logic            hit;
    } stat_t;

    localparam ctrl_t CTRL_NOP = '{
        accept: 1'b0, dispatch: 1'b0, addr_op: A_HOLD, wr_op: W_NONE,
        acc_op: ACC_HOLD, mul_op: M_HOLD, left_op: L_HOLD, cap: 1'b0,
        res_sel: R_ZERO, emit: 1'b0, c1: C_NONE, t1: S_IDLE, c2: C_NONE,
        t2: S_IDLE, t_else: S_IDLE
    };

    // One control word per step. A result step waits on itself until the output is free.
    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = CTRL_NOP;
        unique case (s)
            S_CLEAR: begin
                c.wr_op = W_ZERO;  c.addr_op = A_INC;
                c.c1 = C_CLR_LAST; c.t1 = S_IDLE; c.t_else = S_CLEAR;
            end
            S_IDLE: begin
                c.accept = 1'b1; c.dispatch = 1'b1;
                c.addr_op = A_LOAD; c.acc_op = ACC_CLR;
                c.c1 = C_IN_VALID; c.t_else = S_IDLE;
            end
            S_WR: begin
                c.wr_op = W_VALUE; c.t_else = S_IDLE;
            end
            S_RD0: begin
                c.t_else = S_RD1;
            end
            S_RD1: begin
                c.res_sel = R_RDATA; c.emit = 1'b1;
                c.c1 = C_OUT_FREE; c.t1 = S_IDLE; c.t_else = S_RD1;
            end
            S_FILL: begin
                c.wr_op = W_VALUE; c.addr_op = A_INC;
                c.c1 = C_ADDR_LAST; c.t1 = S_IDLE; c.t_else = S_FILL;
            end
            S_INV_P: begin
                c.addr_op = A_INC; c.t_else = S_INV_W;
            end
            S_INV_W: begin
                c.addr_op = A_INC; c.cap = 1'b1;
                c.c1 = C_GT; c.t1 = S_INV_HIT;
                c.c2 = C_DIX_LAST; c.t2 = S_INV_NONE;
                c.t_else = S_INV_W;
            end
            S_INV_HIT: begin
                c.res_sel = R_CAPM1; c.emit = 1'b1;
                c.c1 = C_OUT_FREE; c.t1 = S_IDLE; c.t_else = S_INV_HIT;
            end
            S_INV_NONE: begin
                c.res_sel = R_ZERO; c.emit = 1'b1;
                c.c1 = C_OUT_FREE; c.t1 = S_IDLE; c.t_else = S_INV_NONE;
            end
            S_SUM_P: begin
                c.addr_op = A_INC; c.t_else = S_SUM_L;
            end
            S_SUM_L: begin
                c.addr_op = A_INC; c.acc_op = ACC_ADD;
                c.c1 = C_DIX_LAST; c.t1 = S_SUM_E; c.t_else = S_SUM_L;
            end
            S_SUM_E: begin
                c.res_sel = R_ACC; c.emit = 1'b1;
                c.c1 = C_OUT_FREE; c.t1 = S_IDLE; c.t_else = S_SUM_E;
            end
            S_Q_P: begin
                c.addr_op = A_INC; c.t_else = S_Q_SUM;
            end
            S_Q_SUM: begin
                c.addr_op = A_INC; c.acc_op = ACC_ADD;
                c.c1 = C_DIX_LAST; c.t1 = S_Q_Z; c.t_else = S_Q_SUM;
            end
            S_Q_Z: begin
                c.mul_op = M_INIT;
                c.c1 = C_ACC_ZERO; c.t1 = S_Q_ZERO; c.t_else = S_Q_MUL;
            end
            S_Q_ZERO: begin
                c.res_sel = R_ZERO; c.emit = 1'b1;
                c.c1 = C_OUT_FREE; c.t1 = S_IDLE; c.t_else = S_Q_ZERO;
            end
            S_Q_MUL: begin
                c.mul_op = M_STEP;
                c.c1 = C_MUL_LAST; c.t1 = S_Q_LD; c.t_else = S_Q_MUL;
            end
            S_Q_LD: begin
                c.left_op = L_LOAD; c.addr_op = A_ZERO; c.t_else = S_Q_P2;
            end
            S_Q_P2: begin
                c.addr_op = A_INC; c.t_else = S_Q_W;
            end
            S_Q_W: begin
                c.addr_op = A_INC; c.left_op = L_SUB; c.cap = 1'b1;
                c.c1 = C_HIT; c.t1 = S_Q_HIT;
                c.c2 = C_DIX_LAST; c.t2 = S_Q_MISS;
                c.t_else = S_Q_W;
            end
            S_Q_HIT: begin
                c.res_sel = R_CAP; c.emit = 1'b1;
                c.c1 = C_OUT_FREE; c.t1 = S_IDLE; c.t_else = S_Q_HIT;
            end
            S_Q_MISS: begin
                c.res_sel = R_SIZEM1; c.emit = 1'b1;
                c.c1 = C_OUT_FREE; c.t1 = S_IDLE; c.t_else = S_Q_MISS;
            end
            default: begin
                c = CTRL_NOP;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/itqe_seq.sv
// Microcode sequencer of the table quantile engine: step counter, ROM fetch and jumps.
module itqe_seq
    import itqe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t pc_reg;
    step_t pc_next;

    function automatic logic cond_true(cond_t c, stat_t s);
        logic r;
        unique case (c)
            C_NONE:      r = 1'b0;
            C_IN_VALID:  r = s.in_valid;
            C_CLR_LAST:  r = s.clr_last;
            C_ADDR_LAST: r = s.addr_last;
            C_DIX_LAST:  r = s.dix_last;
            C_OUT_FREE:  r = s.out_free;
            C_ACC_ZERO:  r = s.acc_zero;
            C_MUL_LAST:  r = s.mul_last;
            C_GT:        r = s.gt;
            C_HIT:       r = s.hit;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic step_t op_entry(logic [OP_W-1:0] op);
        step_t e;
        unique case (op_t'(op))
            OP_WRITE:    e = S_WR;
            OP_READ:     e = S_RD0;
            OP_FILL:     e = S_FILL;
            OP_INVERSE:  e = S_INV_P;
            OP_QUANTILE: e = S_Q_P;
            OP_SUM:      e = S_SUM_P;
            default:     e = S_IDLE;
        endcase
        return e;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        ctrl = ucode(pc_reg);
        priority if (cond_true(ctrl.c1, stat))
        begin
            pc_next = ctrl.dispatch ? op_entry(stat.op) : ctrl.t1;
        end
        else if (cond_true(ctrl.c2, stat))
        begin
            pc_next = ctrl.t2;
        end
        else
        begin
            pc_next = ctrl.t_else;
        end
    end

endmodule

FILE: hw/rtl/integer_table_quantile_engine.sv
// Top level of the table quantile engine: configuration port, table memory and datapath.
//
// Usage. Items arrive on the input channel (in_valid/in_ready with op, index, value and
// fraction) and results leave on the output channel (out_valid/out_ready with result).
// Write and fill produce no result; read, inverse, quantile and sum produce one each.
// The table size register sits at byte address 0 of the APB-style configuration port and
// should be written only while the engine is idle.
//
// Sequencing. A microcoded sequencer runs one program per transaction, and every table walk
// goes through the single read port of the table memory, one entry per cycle. A quantile
// takes two walks plus a 15-step shift-add multiply. A new transaction is taken once the
// previous program returns to its idle step.
//
// Reset. After rst_n is released the engine sweeps the whole table (DEPTH entries, 1024 by
// default) to zero, one entry per cycle, with in_ready low; the configuration port
// works during the sweep.
//
// Stalls. The result is held in an output register. When the receiver stalls, the next
// transaction is still accepted and processed; only its own result step waits until the
// output register is free.
module integer_table_quantile_engine
    import itqe_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            op,
    input  logic signed [IDX_W-1:0]    index,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [FRAC_W-1:0]          fraction,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [RESULT_W-1:0] result
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LW     = (ADDR_W + 1 > SIZE_CFG_W) ? ADDR_W + 1 : SIZE_CFG_W;

    ctrl_t ctrl;
    stat_t stat;

    // Configuration register.
    logic [SIZE_CFG_W-1:0] size_cfg_reg;

    // Table memory and its registered read port.
    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rdata_reg;
    logic [ADDR_W-1:0]     dix_reg;

    // Datapath registers.
    logic [ADDR_W-1:0]          addr_reg;
    logic [ADDR_W-1:0]          addr_next;
    logic [ADDR_W-1:0]          cap_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [MUL_CNT_W-1:0]       cnt_reg;
    logic signed [RESULT_W-1:0] acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [LEFT_W-1:0]   left_reg;
    logic                       out_valid_reg;
    logic signed [RESULT_W-1:0] result_reg;

    logic [LW-1:0]              size_raw;
    logic [LW-1:0]              size_live;
    logic [ADDR_W-1:0]          live_m1;
    logic [ADDR_W-1:0]          idx_clamped;
    logic                       accept;
    logic                       out_free;
    logic                       we;
    logic [ENTRY_BITS-1:0]      wdata;
    logic signed [RESULT_W-1:0] rdata_res;
    logic signed [32:0]         entry33;
    logic signed [32:0]         value33;
    logic signed [PROD_W-1:0]   acc_ext;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [LEFT_W-1:0]   rdata_left;
    logic signed [LEFT_W-1:0]   left_diff;
    logic signed [RESULT_W-1:0] res_mux;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= SIZE_CFG_W'(SIZE_RESET);
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SIZE_CFG))
        begin
            size_cfg_reg <= pwdata[SIZE_CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_SIZE_CFG)
        begin
            prdata = PDATA_W'(size_cfg_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // A size of zero acts as one entry, and a size beyond the memory acts as the full depth.
    always_comb
    begin
        size_raw = LW'(size_cfg_reg);
        priority if (size_raw == '0)
        begin
            size_live = LW'(1);
        end
        else if (size_raw > LW'(DEPTH))
        begin
            size_live = LW'(DEPTH);
        end
        else
        begin
            size_live = size_raw;
        end
        live_m1 = ADDR_W'(size_live - LW'(1));
    end

    always_comb
    begin
        priority if (index[IDX_W-1])
        begin
            idx_clamped = '0;
        end
        else if ($unsigned(index) > IDX_W'(live_m1))
        begin
            idx_clamped = live_m1;
        end
        else
        begin
            idx_clamped = index[ADDR_W-1:0];
        end
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = ctrl.accept;
    assign out_free = !out_valid_reg || out_ready;

    // Entry views at the widths of the accumulator, the comparator and the remainder.
    assign rdata_res  = {{(RESULT_W - ENTRY_BITS){rdata_reg[ENTRY_BITS-1]}}, rdata_reg};
    assign rdata_left = {{(LEFT_W - ENTRY_BITS){rdata_reg[ENTRY_BITS-1]}}, rdata_reg};
    assign entry33    = {{(33 - ENTRY_BITS){rdata_reg[ENTRY_BITS-1]}}, rdata_reg};
    assign value33    = {value_reg[VALUE_W-1], value_reg};
    assign acc_ext    = {{(PROD_W - RESULT_W){acc_reg[RESULT_W-1]}}, acc_reg};
    assign prod_sh    = prod_reg >>> FRAC_W;
    assign left_diff  = left_reg - rdata_left;

    always_comb
    begin
        stat.in_valid  = in_valid;
        stat.op        = op;
        stat.clr_last  = (addr_reg == ADDR_W'(DEPTH - 1));
        stat.addr_last = (addr_reg == live_m1);
        stat.dix_last  = (dix_reg == live_m1);
        stat.out_free  = out_free;
        stat.acc_zero  = (acc_reg == '0);
        stat.mul_last  = (cnt_reg == MUL_CNT_W'(FRAC_W - 1));
        stat.gt        = (entry33 > value33);
        stat.hit       = left_diff[LEFT_W-1] || (left_diff == '0);
    end

    itqe_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Write port of the table: the clearing sweep writes zero, write and fill the value.
    always_comb
    begin
        we    = (ctrl.wr_op != W_NONE);
        wdata = (ctrl.wr_op == W_VALUE) ? value_reg[ENTRY_BITS-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr_reg] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
        dix_reg   <= addr_reg;
    end

    always_comb
    begin
        unique case (ctrl.addr_op)
            A_HOLD: addr_next = addr_reg;
            A_LOAD: addr_next = (op_t'(op) == OP_WRITE || op_t'(op) == OP_READ) ?
                                idx_clamped : '0;
            A_ZERO: addr_next = '0;
            A_INC:  addr_next = addr_reg + ADDR_W'(1);
            default: addr_next = addr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
        end

        if (ctrl.cap)
        begin
            cap_reg <= dix_reg;
        end

        unique case (ctrl.acc_op)
            ACC_CLR:  acc_reg <= '0;
            ACC_ADD:  acc_reg <= acc_reg + rdata_res;
            default:  acc_reg <= acc_reg;
        endcase

        // Shift-add multiply, most significant fraction bit first.
        if (accept)
        begin
            frac_reg <= fraction;
        end
        else if (ctrl.mul_op == M_STEP)
        begin
            frac_reg <= frac_reg << 1;
        end

        unique case (ctrl.mul_op)
            M_INIT:
            begin
                prod_reg <= '0;
                cnt_reg  <= '0;
            end
            M_STEP:
            begin
                prod_reg <= (prod_reg <<< 1) + (frac_reg[FRAC_W-1] ? acc_ext : '0);
                cnt_reg  <= cnt_reg + MUL_CNT_W'(1);
            end
            default:
            begin
                prod_reg <= prod_reg;
                cnt_reg  <= cnt_reg;
            end
        endcase

        unique case (ctrl.left_op)
            L_LOAD:  left_reg <= prod_sh[LEFT_W-1:0] + LEFT_W'(1);
            L_SUB:   left_reg <= left_diff;
            default: left_reg <= left_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.res_sel)
            R_RDATA:  res_mux = rdata_res;
            R_ACC:    res_mux = acc_reg;
            R_ZERO:   res_mux = '0;
            R_CAP:    res_mux = RESULT_W'(cap_reg);
            R_CAPM1:  res_mux = (cap_reg == '0) ? '0 : RESULT_W'(cap_reg - ADDR_W'(1));
            R_SIZEM1: res_mux = RESULT_W'(live_m1);
            default:  res_mux = '0;
        endcase
    end

    // Output register: loads when the result step finds it free, clears when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit && out_free)
        begin
            result_reg <= res_mux;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

FILE: hw/rtl/itqe_checker.sv
// Port-level checker of the table quantile engine and its bind to the top level.
module itqe_checker
    import itqe_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [OP_W-1:0]            op,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [RESULT_W-1:0] result
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // A read has out_valid high once it has gone through its steps S_RD0 and S_RD1.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_READ) |-> ##3 out_valid)
        else $error("read result missing");

    // A write occupies the engine for its single write step S_WR, then returns to idle.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_WRITE) |=> !in_ready ##1 in_ready)
        else $error("write did not return to idle on time");

    // An idle engine stays idle when nothing arrives.
    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("engine left idle without a transaction");

endmodule

bind integer_table_quantile_engine itqe_checker u_itqe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
);
